// ----- hw/rtl/csvtok_pkg.sv -----
// shared types, constants and helpers of the csv field tokenizer
package csvtok_pkg;

    localparam logic [7:0] QUOTE_BYTE      = 8'h22;
    localparam logic [7:0] NEWLINE_BYTE    = 8'h0A;
    localparam logic [7:0] DELIM_RESET     = 8'h2C;

    localparam logic [1:0] KIND_BYTE       = 2'd0;
    localparam logic [1:0] KIND_FIELD_END  = 2'd1;
    localparam logic [1:0] KIND_EMPTY      = 2'd2;
    localparam logic [1:0] KIND_END        = 2'd3;

    // result queue: room for two results of one item plus slack for a stalled sink
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic       field_started;
        logic       in_quotes;
        logic       after_inner_quote;
    } t_tok_state;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] field_byte;
        logic       last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
        t_tok_state nxt;
    } t_dec_out;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) ||
                   (c == 8'h0C) || (c == 8'h0D);
    endfunction

    function automatic t_result mk_res(input logic [1:0] kind, input logic [7:0] b);
        t_result r;
        r.kind        = kind;
        r.field_byte  = (kind == KIND_BYTE) ? b : 8'h00;
        r.last_of_run = 1'b0;
        mk_res = r;
    endfunction

endpackage

// ----- hw/rtl/csvtok_decode.sv -----
// per-byte decision logic: next field state and up to two results
module csvtok_decode (
    input  csvtok_pkg::t_tok_state i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_end,
    input  logic [7:0]             i_delim,
    output csvtok_pkg::t_dec_out   o_dec
);
    import csvtok_pkg::*;

    t_dec_out   d;
    t_tok_state clr;

    always_comb begin
        clr = '0;
        d = '0;
        d.nxt = i_state;
        priority if (i_end) begin
            if (i_state.field_started) begin
                d.res0  = mk_res(KIND_FIELD_END, 8'h00);
                d.res1  = mk_res(KIND_END, 8'h00);
                d.count = 2'd2;
            end else begin
                d.res0  = mk_res(KIND_END, 8'h00);
                d.count = 2'd1;
            end
            d.nxt = clr;
        end else if (i_state.after_inner_quote) begin
            d.count = 2'd1;
            if (i_byte == i_delim || i_byte == NEWLINE_BYTE) begin
                d.res0 = mk_res(KIND_FIELD_END, 8'h00);
                d.nxt  = clr;
            end else begin
                d.res0 = mk_res(KIND_BYTE, i_byte);
                d.nxt.after_inner_quote = 1'b0;
                d.nxt.field_started     = 1'b1;
            end
        end else if (!i_state.in_quotes && i_byte == i_delim) begin
            d.res0  = mk_res(i_state.field_started ? KIND_FIELD_END : KIND_EMPTY, 8'h00);
            d.count = 2'd1;
            d.nxt   = clr;
        end else if (i_byte == NEWLINE_BYTE) begin
            if (i_state.field_started) begin
                d.res0  = mk_res(KIND_FIELD_END, 8'h00);
                d.res1  = mk_res(KIND_EMPTY, 8'h00);
                d.count = 2'd2;
            end else begin
                d.res0  = mk_res(KIND_EMPTY, 8'h00);
                d.count = 2'd1;
            end
            d.nxt = clr;
        end else if (!i_state.field_started && !i_state.in_quotes && is_blank(i_byte)) begin
            // leading whitespace dropped
            d.count = 2'd0;
        end else if (!i_state.field_started && i_byte == QUOTE_BYTE) begin
            d.nxt.in_quotes = 1'b1;
        end else if (i_byte == QUOTE_BYTE && i_state.in_quotes) begin
            d.nxt.after_inner_quote = 1'b1;
        end else begin
            d.res0  = mk_res(KIND_BYTE, i_byte);
            d.count = 2'd1;
            d.nxt.field_started = 1'b1;
        end

        if (d.count == 2'd1) begin
            d.res0.last_of_run = 1'b1;
        end
        if (d.count == 2'd2) begin
            d.res1.last_of_run = 1'b1;
        end
        o_dec = d;
    end

endmodule

// ----- hw/rtl/csvtok_outq.sv -----
// small result queue: takes up to two results per cycle, hands out one while the sink is ready
module csvtok_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_cnt,
    input  csvtok_pkg::t_result i_res0,
    input  csvtok_pkg::t_result i_res1,
    output logic                o_room2,
    output logic                o_valid,
    input  logic                i_ready,
    output csvtok_pkg::t_result o_res
);
    import csvtok_pkg::*;

    t_result          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [OQ_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [OQ_CW-1:0] r_count, n_count;
    logic             pop;
    logic [OQ_AW-1:0] wr_ptr1;
    logic [OQ_CW-1:0] after_pop;

    assign pop       = o_valid && i_ready;
    assign o_valid   = (r_count != '0);
    assign o_res     = r_mem[r_rd_ptr];
    assign wr_ptr1   = r_wr_ptr + OQ_AW'(1);
    assign after_pop = r_count - OQ_CW'(pop);
    assign o_room2   = (after_pop <= OQ_CW'(OQ_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + OQ_AW'(i_push_cnt);
        n_rd_ptr = r_rd_ptr + OQ_AW'(pop);
        n_count  = after_pop + OQ_CW'(i_push_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_res1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OQ_CW'(OQ_DEPTH))
        else $error("result queue count beyond depth");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |-> o_room2)
        else $error("results pushed without room in queue");

endmodule

// ----- hw/rtl/csv_field_tokenizer_core.sv -----
// csv field tokenizer top level: input register, field state, result queue
// One byte item is taken per cycle while the queue has room. An item is held in an
// input register, decoded against the field state and the delimiter, and its zero,
// one or two results go into a four-entry result queue that drives the output
// channel. Input flows at one item per cycle while the sink takes results as fast
// as they are made; items that give two results (a newline after field data, end
// of input after field data) need two output transfers, so the output port sets
// the sustained rate. The delimiter register (reset ',') is written through the
// config channel, which is always ready; write it only while no item is in flight.
module csv_field_tokenizer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_delimiter_char,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_input,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_field_byte,
    output logic       o_last_of_run
);
    import csvtok_pkg::*;

    logic [7:0] r_delim;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    t_tok_state r_state;
    t_dec_out   dec;
    logic       room2;
    logic       advance;
    logic [1:0] push_cnt;
    t_result    out_res;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && room2;
    assign o_in_ready  = !r_in_valid || advance;
    assign push_cnt    = advance ? dec.count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_delim <= i_cfg_delimiter_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state <= dec.nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_end_of_input;
        end
    end

    csvtok_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .i_delim (r_delim),
        .o_dec   (dec)
    );

    csvtok_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (dec.res0),
        .i_res1     (dec.res1),
        .o_room2    (room2),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (out_res)
    );

    assign o_kind        = out_res.kind;
    assign o_field_byte  = out_res.field_byte;
    assign o_last_of_run = out_res.last_of_run;

    // a pending inner quote only exists inside a quoted field with data
    a_quote_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.after_inner_quote |-> (r_state.in_quotes && r_state.field_started))
        else $error("inner quote pending outside a started quoted field");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_end) |=> (r_state == '0))
        else $error("field state not cleared after end of input");

    a_two_results_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_cnt == 2'd2) |-> (!dec.res0.last_of_run && dec.res1.last_of_run))
        else $error("last_of_run misplaced on a two-result item");

endmodule

// ----- bench/csv_field_tokenizer_core_test.sv -----
// self-checking bench for the csv field tokenizer core: directed table, then random streams
module csv_field_tokenizer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import csvtok_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       eoi;
        bit         fixed;
        int         n_res;
        t_result    r0;
        t_result    r1;
    } t_byte_row;

    localparam t_result NO_RES = '0;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_delimiter_char = 8'h00;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_end_of_input = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_field_byte;
    logic       o_last_of_run;

    // typed-in expectation travels with the item payload
    bit         cur_fixed = 1'b0;
    int         cur_n = 0;
    t_result    cur_r0 = '0;
    t_result    cur_r1 = '0;

    bit         calm = 1'b0;
    int         mismatches = 0;
    int         stall_left = 0;

    // tokenizer state as predicted
    logic [7:0] delim = DELIM_RESET;
    logic       fld_started = 1'b0;
    logic       quoted = 1'b0;
    logic       quote_pending = 1'b0;

    t_result    step_tokens[$];
    t_result    pending_tokens[$];
    t_byte_row  dir_rows[$];

    csv_field_tokenizer_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_delimiter_char (i_cfg_delimiter_char),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_data_byte          (i_data_byte),
        .i_end_of_input       (i_end_of_input),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_kind               (o_kind),
        .o_field_byte         (o_field_byte),
        .o_last_of_run        (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result tok_res(input logic [1:0] k, input logic [7:0] b,
                                        input logic l);
        t_result r;
        r.kind        = k;
        r.field_byte  = b;
        r.last_of_run = l;
        return r;
    endfunction

    function automatic void emit(input logic [1:0] k, input logic [7:0] b);
        step_tokens.push_back(tok_res(k, (k == KIND_BYTE) ? b : 8'h00, 1'b0));
    endfunction

    function automatic void clear_field();
        fld_started   = 1'b0;
        quoted        = 1'b0;
        quote_pending = 1'b0;
    endfunction

    // work out the tokens one input item gives and advance the field state
    function automatic void tokenize(input logic [7:0] c, input logic eoi);
        logic blank;
        blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) ||
                (c == 8'h0D);
        step_tokens.delete();
        if (eoi) begin
            if (fld_started)
                emit(KIND_FIELD_END, 8'h00);
            emit(KIND_END, 8'h00);
            clear_field();
        end else if (quote_pending) begin
            quote_pending = 1'b0;
            if (c == delim || c == NEWLINE_BYTE) begin
                emit(KIND_FIELD_END, 8'h00);
                clear_field();
            end else begin
                emit(KIND_BYTE, c);
                fld_started = 1'b1;
            end
        end else if (!quoted && c == delim) begin
            emit(fld_started ? KIND_FIELD_END : KIND_EMPTY, 8'h00);
            clear_field();
        end else if (c == NEWLINE_BYTE) begin
            if (fld_started)
                emit(KIND_FIELD_END, 8'h00);
            emit(KIND_EMPTY, 8'h00);
            clear_field();
        end else if (!fld_started && !quoted && blank) begin
            // leading whitespace dropped
        end else if (!fld_started && c == QUOTE_BYTE) begin
            quoted = 1'b1;
        end else if (c == QUOTE_BYTE && quoted) begin
            quote_pending = 1'b1;
        end else begin
            emit(KIND_BYTE, c);
            fld_started = 1'b1;
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    endfunction

    task automatic report_error(input string msg);
        if (mismatches < 50)
            $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // predict on accepted items, check accepted results, drive sink stalls
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                delim = i_cfg_delimiter_char;
            if (i_in_valid && o_in_ready) begin
                tokenize(i_data_byte, i_end_of_input);
                if (cur_fixed) begin
                    if (cur_n > 0) pending_tokens.push_back(cur_r0);
                    if (cur_n > 1) pending_tokens.push_back(cur_r1);
                end else begin
                    foreach (step_tokens[k]) pending_tokens.push_back(step_tokens[k]);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_tokens.size() == 0) begin
                    report_error($sformatf("unexpected result kind %0d byte %02h last %0b",
                                           o_kind, o_field_byte, o_last_of_run));
                end else begin
                    want = pending_tokens.pop_front();
                    if (o_kind !== want.kind)
                        report_error($sformatf("kind %0d, want %0d", o_kind, want.kind));
                    if (o_field_byte !== want.field_byte)
                        report_error($sformatf("field_byte %02h, want %02h",
                                               o_field_byte, want.field_byte));
                    if (o_last_of_run !== want.last_of_run)
                        report_error($sformatf("last_of_run %0b, want %0b",
                                               o_last_of_run, want.last_of_run));
                end
            end
        end
        if (calm) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic void add_row(input logic [7:0] d, input logic e, input bit fx,
                                    input int n, input t_result r0, input t_result r1);
        t_byte_row row;
        row.data  = d;
        row.eoi   = e;
        row.fixed = fx;
        row.n_res = n;
        row.r0    = r0;
        row.r1    = r1;
        dir_rows.push_back(row);
    endfunction

    // mostly csv-shaped bytes for the current delimiter, some arbitrary ones
    function automatic t_byte_row random_row();
        t_byte_row row;
        int        pick;
        row.fixed = 1'b0;
        row.n_res = 0;
        row.r0    = NO_RES;
        row.r1    = NO_RES;
        row.eoi   = 1'b0;
        row.data  = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            row.data = delim;
        end else if (pick < 28) begin
            row.data = NEWLINE_BYTE;
        end else if (pick < 42) begin
            row.data = QUOTE_BYTE;
        end else if (pick < 52) begin
            case ($urandom_range(0, 4))
                0: row.data = 8'h20;
                1: row.data = 8'h09;
                2: row.data = 8'h0B;
                3: row.data = 8'h0C;
                default: row.data = 8'h0D;
            endcase
        end else if (pick < 55) begin
            row.eoi = 1'b1;
        end else if (pick < 80) begin
            row.data = 8'($urandom_range(8'h61, 8'h7A));
        end
        return row;
    endfunction

    task automatic send_row(input t_byte_row row);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= row.data;
        i_end_of_input <= row.eoi;
        cur_fixed      <= row.fixed;
        cur_n          <= row.n_res;
        cur_r0         <= row.r0;
        cur_r1         <= row.r1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // hold the sender until every expected result is out and the pipe is empty
    task automatic drain_results();
        i_in_valid <= 1'b0;
        // let the checker take in the last accepted item first
        @(posedge i_clk);
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_delimiter(input logic [7:0] v);
        drain_results();
        i_cfg_valid          <= 1'b1;
        i_cfg_delimiter_char <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] delim_plan [8];
        delim_plan[0] = DELIM_RESET;
        delim_plan[1] = 8'h00;
        delim_plan[2] = 8'hFF;
        delim_plan[3] = QUOTE_BYTE;
        delim_plan[4] = NEWLINE_BYTE;
        delim_plan[5] = 8'h09;
        delim_plan[6] = 8'($urandom_range(0, 255));
        delim_plan[7] = DELIM_RESET;

        // end of input straight after reset, blank skip, empty field
        add_row(8'h5A, 1'b1, 1'b1, 1, tok_res(KIND_END, 8'h00, 1'b1), NO_RES);
        add_row(8'h20, 1'b0, 1'b1, 0, NO_RES, NO_RES);
        add_row(8'h2C, 1'b0, 1'b1, 1, tok_res(KIND_EMPTY, 8'h00, 1'b1), NO_RES);
        add_row(8'h61, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(8'h2C, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        // quoted field: literal delimiter, doubled quote, close on newline
        add_row(QUOTE_BYTE, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(8'h2C, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(QUOTE_BYTE, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(QUOTE_BYTE, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(QUOTE_BYTE, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(NEWLINE_BYTE, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        // quote before data twice, then newline inside quotes
        add_row(QUOTE_BYTE, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(QUOTE_BYTE, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(8'h78, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(NEWLINE_BYTE, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(NEWLINE_BYTE, 1'b0, 1'b1, 1, tok_res(KIND_EMPTY, 8'h00, 1'b1), NO_RES);
        // byte extremes, quote and blanks after data are plain bytes
        add_row(8'hFF, 1'b0, 1'b1, 1, tok_res(KIND_BYTE, 8'hFF, 1'b1), NO_RES);
        add_row(8'h00, 1'b0, 1'b1, 1, tok_res(KIND_BYTE, 8'h00, 1'b1), NO_RES);
        add_row(QUOTE_BYTE, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(8'h09, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(8'hA5, 1'b1, 1'b1, 2, tok_res(KIND_FIELD_END, 8'h00, 1'b0),
                tok_res(KIND_END, 8'h00, 1'b1));
        // end of input with an inner quote pending
        add_row(QUOTE_BYTE, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(8'h71, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(QUOTE_BYTE, 1'b0, 1'b0, 0, NO_RES, NO_RES);
        add_row(8'h3C, 1'b1, 1'b1, 2, tok_res(KIND_FIELD_END, 8'h00, 1'b0),
                tok_res(KIND_END, 8'h00, 1'b1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            send_row(dir_rows[k]);

        for (int phase = 0; phase < 8; phase++) begin
            if (phase > 0)
                write_delimiter(delim_plan[phase]);
            if (phase == 7)
                calm <= 1'b1;
            for (int k = 0; k < 140; k++) begin
                if (phase == 2 && k == 70)
                    drain_results();
                send_row(random_row());
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/csvtok_pkg.sv
hw/rtl/csvtok_decode.sv
hw/rtl/csvtok_outq.sv
hw/rtl/csv_field_tokenizer_core.sv
bench/csv_field_tokenizer_core_test.sv
